>>> rtl/core/bhd_pkg.sv
// Shared types, widths and blend helpers for the bilinear half-size downscaler.
// Used by bhd_fifo, bhd_front, bhd_back and the top level; has no dependencies of its own.

package bhd_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 4096;
    localparam int FRAC_W     = 16;            // fraction bits of the 2.16 steps
    localparam int CFG_SIZE_W = 13;
    localparam int CFG_STEP_W = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 32;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WSZ_W     = (COL_W + 1 > CFG_SIZE_W) ? COL_W + 1 : CFG_SIZE_W;
    localparam int ROW_W     = CFG_SIZE_W;
    localparam int STEP_IP_W = (CFG_STEP_W > FRAC_W) ? CFG_STEP_W - FRAC_W : 1;
    localparam int XIP_W     = ((WSZ_W > STEP_IP_W) ? WSZ_W : STEP_IP_W) + 1;
    localparam int YIP_W     = ((ROW_W > STEP_IP_W) ? ROW_W : STEP_IP_W) + 1;
    localparam int XPOS_W    = XIP_W + FRAC_W;
    localparam int YPOS_W    = YIP_W + FRAC_W;
    localparam int OCOL_W    = COL_W;
    localparam int OROW_W    = ROW_W - 1;
    localparam int PROD_W    = FRAC_W + 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA  = 3'd4;

    // Register reset values
    localparam logic [CFG_SIZE_W-1:0] RST_SRC_WIDTH  = 13'd1024;
    localparam logic [CFG_SIZE_W-1:0] RST_SRC_HEIGHT = 13'd1024;
    localparam logic [CFG_STEP_W-1:0] RST_X_STEP     = 18'd131200;
    localparam logic [CFG_STEP_W-1:0] RST_Y_STEP     = 18'd131200;

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] src_width;
        logic [CFG_SIZE_W-1:0] src_height;
        logic [CFG_STEP_W-1:0] x_step;
        logic [CFG_STEP_W-1:0] y_step;
        logic                  has_alpha;
    } t_cfg;

    // One blend job: four corners, the two weights and the frame-last flag
    typedef struct packed {
        logic [PIX_W-1:0]  tl;
        logic [PIX_W-1:0]  tr;
        logic [PIX_W-1:0]  bl;
        logic [PIX_W-1:0]  br;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic              last;
    } t_job;

    // a*(1-f) + b*f == a*2^F + (b-a)*f; this gives the product term
    function automatic logic signed [PROD_W-1:0] lerp_mul(
        input logic [7:0]        a,
        input logic [7:0]        b,
        input logic [FRAC_W-1:0] f
    );
        logic signed [8:0]        d;
        logic signed [PROD_W-1:0] de;
        logic signed [PROD_W-1:0] fe;
        d  = $signed({1'b0, b}) - $signed({1'b0, a});
        de = PROD_W'(d);
        fe = $signed({{(PROD_W-FRAC_W){1'b0}}, f});
        return de * fe;
    endfunction

    // add the base term and truncate away the fraction
    function automatic logic [7:0] lerp_fin(
        input logic [7:0]               a,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] s;
        s = $signed({2'b00, a, {FRAC_W{1'b0}}}) + p;
        return s[FRAC_W+7:FRAC_W];
    endfunction

endpackage

>>> rtl/core/bhd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.

module bhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/bhd_fifo.sv
// Short job queue between the front (pixel classification) and the back (blend).
// Depends on bhd_pkg for t_job and the queue depth.

module bhd_fifo
    import bhd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job queue pushed while full");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && !o_full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("job queue count did not follow a push");
`endif

endmodule

>>> rtl/core/bhd_front.sv
// Front part: accepts source pixels, tracks raster and sample positions,
// keeps the line buffer and issues blend jobs. Depends on bhd_pkg and bhd_ram.

module bhd_front
    import bhd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_push,
    output t_job             o_job,
    input  logic             i_full
);

    logic [COL_W-1:0]  r_src_column, n_src_column;
    logic [ROW_W-1:0]  r_src_row, n_src_row;
    logic [OCOL_W-1:0] r_out_column, n_out_column;
    logic [OROW_W-1:0] r_out_row, n_out_row;
    logic [XPOS_W-1:0] r_x_pos, n_x_pos;
    logic [YPOS_W-1:0] r_y_pos, n_y_pos;
    logic [PIX_W-1:0]  r_left, r_left_upper;
    logic [PIX_W-1:0]  upper;

    logic [WSZ_W-1:0]  w_raw, w_eff, wm1, x1, x2, col_ext;
    logic [ROW_W-1:0]  h_eff, hm1, y1, y2;
    logic [OCOL_W-1:0] ow;
    logic [OROW_W-1:0] oh;
    logic [XIP_W-1:0]  x_ip;
    logic [YIP_W-1:0]  y_ip;
    logic              accept, emit_hit, col_end, row_adv, frame_end, x_eq, y_eq;
    logic [PIX_W-1:0]  bl;

    // effective sizes
    always_comb begin
        w_raw = WSZ_W'(i_cfg.src_width);
        if (w_raw > WSZ_W'(MAX_WIDTH)) begin
            w_eff = WSZ_W'(MAX_WIDTH);
        end else if (w_raw == '0) begin
            w_eff = WSZ_W'(1);
        end else begin
            w_eff = w_raw;
        end
        h_eff = (i_cfg.src_height == '0) ? ROW_W'(1) : i_cfg.src_height;
    end

    assign wm1 = w_eff - 1'b1;
    assign hm1 = h_eff - 1'b1;
    assign ow  = OCOL_W'(w_eff >> 1);
    assign oh  = OROW_W'(h_eff >> 1);

    // integer parts, clamped to the last column / row
    assign x_ip = r_x_pos[XPOS_W-1:FRAC_W];
    assign y_ip = r_y_pos[YPOS_W-1:FRAC_W];
    assign x1   = (x_ip > XIP_W'(wm1)) ? wm1 : WSZ_W'(x_ip);
    assign y1   = (y_ip > YIP_W'(hm1)) ? hm1 : ROW_W'(y_ip);
    assign x2   = (x1 != wm1) ? x1 + 1'b1 : wm1;
    assign y2   = (y1 != hm1) ? y1 + 1'b1 : hm1;
    assign x_eq = (x1 == x2);
    assign y_eq = (y1 == y2);

    assign col_ext   = WSZ_W'(r_src_column);
    assign emit_hit  = (r_out_row < oh) && (r_out_column < ow) &&
                       (r_src_row == y2) && (col_ext == x2);
    assign col_end   = (col_ext >= wm1);
    assign row_adv   = (r_out_row < oh) && (r_src_row >= y2);
    assign frame_end = (r_src_row >= hm1);

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit_hit;

    // corner selection; clamped neighbours collapse onto the current pixel
    assign bl = x_eq ? i_pixel : r_left;
    always_comb begin
        o_job.br   = i_pixel;
        o_job.bl   = bl;
        o_job.tr   = y_eq ? i_pixel : upper;
        o_job.tl   = y_eq ? bl : (x_eq ? upper : r_left_upper);
        o_job.fx   = r_x_pos[FRAC_W-1:0];
        o_job.fy   = r_y_pos[FRAC_W-1:0];
        o_job.last = (r_out_row == oh - 1'b1) && (r_out_column == ow - 1'b1);
    end

    always_comb begin
        n_src_column = r_src_column;
        n_src_row    = r_src_row;
        n_out_column = r_out_column;
        n_out_row    = r_out_row;
        n_x_pos      = r_x_pos;
        n_y_pos      = r_y_pos;
        if (accept) begin
            if (emit_hit) begin
                n_out_column = r_out_column + 1'b1;
                n_x_pos      = r_x_pos + XPOS_W'(i_cfg.x_step);
            end
            if (col_end) begin
                n_src_column = '0;
                n_out_column = '0;
                n_x_pos      = '0;
                if (row_adv) begin
                    n_out_row = r_out_row + 1'b1;
                    n_y_pos   = r_y_pos + YPOS_W'(i_cfg.y_step);
                end
                if (frame_end) begin
                    n_src_row = '0;
                    n_out_row = '0;
                    n_y_pos   = '0;
                end else begin
                    n_src_row = r_src_row + 1'b1;
                end
            end else begin
                n_src_column = r_src_column + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_column <= '0;
            r_src_row    <= '0;
            r_out_column <= '0;
            r_out_row    <= '0;
            r_x_pos      <= '0;
            r_y_pos      <= '0;
        end else begin
            r_src_column <= n_src_column;
            r_src_row    <= n_src_row;
            r_out_column <= n_out_column;
            r_out_row    <= n_out_row;
            r_x_pos      <= n_x_pos;
            r_y_pos      <= n_y_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left       <= i_pixel;
            r_left_upper <= upper;
        end
    end

    // read address runs one column ahead so the word above is ready on accept
    bhd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_src_column),
        .i_wr_data (i_pixel),
        .i_rd_addr (n_src_column),
        .o_rd_data (upper)
    );

`ifndef SYNTHESIS
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_end) |=> (r_src_column == '0 && r_out_column == '0 && r_x_pos == '0))
        else $error("row end did not restart the column counters");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_end && frame_end) |=> (r_src_row == '0 && r_out_row == '0))
        else $error("frame end did not restart the row counters");
`endif

endmodule

>>> rtl/core/bhd_back.sv
// Back part: four-stage blend pipeline (horizontal pass, vertical pass) ending in the
// output register. Depends on bhd_pkg for t_job and the blend helpers.

module bhd_back
    import bhd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_has_alpha,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_last
);

    logic                     en;
    logic                     r1_valid, r2_valid, r3_valid, r_out_valid;
    logic [7:0]               r1_a_t [4];
    logic [7:0]               r1_a_b [4];
    logic signed [PROD_W-1:0] r1_p_t [4];
    logic signed [PROD_W-1:0] r1_p_b [4];
    logic [FRAC_W-1:0]        r1_fy, r2_fy;
    logic                     r1_last, r2_last, r3_last, r_out_last;
    logic [7:0]               r2_top [4];
    logic [7:0]               r2_bot [4];
    logic [7:0]               r3_a [4];
    logic signed [PROD_W-1:0] r3_p [4];
    logic [7:0]               r_out_ch [4];

    // whole pipe holds while the result waits
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_job_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < 4; ch++) begin
                r1_a_t[ch] <= i_job.tl[8*ch +: 8];
                r1_a_b[ch] <= i_job.bl[8*ch +: 8];
                r1_p_t[ch] <= lerp_mul(i_job.tl[8*ch +: 8], i_job.tr[8*ch +: 8], i_job.fx);
                r1_p_b[ch] <= lerp_mul(i_job.bl[8*ch +: 8], i_job.br[8*ch +: 8], i_job.fx);
                r2_top[ch] <= lerp_fin(r1_a_t[ch], r1_p_t[ch]);
                r2_bot[ch] <= lerp_fin(r1_a_b[ch], r1_p_b[ch]);
                r3_a[ch]   <= r2_top[ch];
                r3_p[ch]   <= lerp_mul(r2_top[ch], r2_bot[ch], r2_fy);
                r_out_ch[ch] <= lerp_fin(r3_a[ch], r3_p[ch]);
            end
            r1_fy      <= i_job.fy;
            r2_fy      <= r1_fy;
            r1_last    <= i_job.last;
            r2_last    <= r1_last;
            r3_last    <= r2_last;
            r_out_last <= r3_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_last  = r_out_last;
    assign o_pixel = {i_has_alpha ? r_out_ch[3] : 8'd0, r_out_ch[2], r_out_ch[1], r_out_ch[0]};

`ifndef SYNTHESIS
    a_pipe_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && en) |=> r_out_valid)
        else $error("vertical stage result lost on its way to the output");
`endif

endmodule

>>> rtl/core/bilinear_half_downscaler.sv
// Bilinear half-size downscaler for a raster stream of 32-bit RGBA pixels:
// one source pixel is taken per clock whenever the job queue has room, and
// each job, issued with its bottom-right source pixel, runs through the queue
// and the stages horizontal multiply, horizontal sum, vertical multiply and sum.
// The rate is set by the single write and read port of the line buffer, one
// pixel per clock; the blend pipeline runs at one job per clock while the output
// is ready. The line buffer holds 4096 words, is not cleared after reset, and its
// data is used only where the row above has already been written. Configuration
// is written on its own channel, always ready, and must only be changed while the
// block is idle. Depends on bhd_pkg, bhd_front, bhd_fifo and bhd_back.

module bilinear_half_downscaler
    import bhd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // source pixels
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // [7:0] in_red, [15:8] in_green,
                                                 // [23:16] in_blue, [31:24] in_alpha
    // output pixels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // [7:0] out_red, [15:8] out_green,
                                                 // [23:16] out_blue, [31:24] out_alpha
    output logic                  m_axis_tlast   // frame_last
);

    t_cfg r_cfg;
    logic front_push, queue_full, queue_valid, back_pop;
    t_job front_job, queue_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= RST_SRC_WIDTH;
            r_cfg.src_height <= RST_SRC_HEIGHT;
            r_cfg.x_step     <= RST_X_STEP;
            r_cfg.y_step     <= RST_Y_STEP;
            r_cfg.has_alpha  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[CFG_SIZE_W-1:0];
                REG_X_STEP:     r_cfg.x_step     <= i_cfg_data[CFG_STEP_W-1:0];
                REG_Y_STEP:     r_cfg.y_step     <= i_cfg_data[CFG_STEP_W-1:0];
                REG_HAS_ALPHA:  r_cfg.has_alpha  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pixel (s_axis_tdata),
        .o_push  (front_push),
        .o_job   (front_job),
        .i_full  (queue_full)
    );

    bhd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    bhd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_has_alpha (r_cfg.has_alpha),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_pop       (back_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel     (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
